// ===== hw/rtl/wfdc_pkg.sv =====
// ----------------------------------------------------------------------------
// wfdc_pkg
// Shared types and constants for the wall-following drive control block.
// ----------------------------------------------------------------------------
`default_nettype none

package wfdc_pkg;

    // Drive mode codes
    localparam logic [2:0] MODE_STOP   = 3'd0;
    localparam logic [2:0] MODE_FWD    = 3'd1;
    localparam logic [2:0] MODE_BACK   = 3'd2;
    localparam logic [2:0] MODE_SPIN_R = 3'd3;
    localparam logic [2:0] MODE_SPIN_L = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_FAST_MODE  = 3'd0;
    localparam logic [2:0] REG_GAIN       = 3'd1;
    localparam logic [2:0] REG_NEAR_LIMIT = 3'd2;
    localparam logic [2:0] REG_FAR_LIMIT  = 3'd3;
    localparam logic [2:0] REG_DUTY_SWING = 3'd4;

    // Duties (PWM counts)
    localparam logic [13:0] NOM_SLOW        = 14'd3750;
    localparam logic [13:0] NOM_FAST        = 14'd5000;
    localparam logic [13:0] TURN_SLOW_DUTY  = 14'd1500;
    localparam logic [13:0] BACK_LEFT_DUTY  = 14'd2500;
    localparam logic [13:0] BACK_RIGHT_DUTY = 14'd3750;

    // Distances (mm)
    localparam logic [11:0] OPEN_SIDE_MM  = 12'd500;
    localparam logic [11:0] SIDE_CLEAR_MM = 12'd350;
    localparam logic [11:0] FRONT_SLOW_MM = 12'd400;
    localparam logic [11:0] STUCK_SLOW_MM = 12'd375;
    localparam logic [11:0] FRONT_FAST_MM = 12'd250;
    localparam logic [11:0] STUCK_FAST_MM = 12'd225;
    // stuck threshold plus reverse distance (375 + 75, 225 + 125)
    localparam logic [11:0] EXIT_SLOW_MM  = 12'd450;
    localparam logic [11:0] EXIT_FAST_MM  = 12'd350;

    // Reset values of the configuration registers
    localparam logic [5:0]  GAIN_RST       = 6'd10;
    localparam logic [11:0] NEAR_LIMIT_RST = 12'd250;
    localparam logic [11:0] FAR_LIMIT_RST  = 12'd350;
    localparam logic [12:0] DUTY_SWING_RST = 13'd2250;

    typedef struct packed {
        logic [11:0] left_mm;
        logic [11:0] center_mm;
        logic [11:0] right_mm;
        logic        bump;
    } item_t;

    // Config registers plus values derived from them
    typedef struct packed {
        logic        fast_mode;
        logic [5:0]  gain;
        logic [11:0] near_limit_mm;
        logic [11:0] far_limit_mm;
        logic [11:0] mid_mm;
        logic [13:0] clamp_lo;
        logic [13:0] clamp_hi;
    } cfg_t;

    typedef struct packed {
        logic        reversing;
        logic [2:0]  held_mode;
        logic [13:0] held_left_duty;
        logic [13:0] held_right_duty;
    } state_t;

    typedef struct packed {
        logic [2:0]  drive_mode;
        logic [13:0] left_duty;
        logic [13:0] right_duty;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wfdc_decide.sv =====
// ----------------------------------------------------------------------------
// wfdc_decide
// Decision chain for one control tick: result and next controller state.
// ----------------------------------------------------------------------------
`default_nettype none

module wfdc_decide (
    input  wire wfdc_pkg::item_t   item,
    input  wire wfdc_pkg::cfg_t    cfg,
    input  wire wfdc_pkg::state_t  st,
    output wfdc_pkg::result_t      res,
    output wfdc_pkg::state_t       st_next
);

    logic [13:0]        nom;
    logic [11:0]        front_mm;
    logic [11:0]        stuck_mm;
    logic [11:0]        exit_mm;
    logic               l_out_band;
    logic               r_out_band;
    logic               follow_l;
    logic               follow_r;
    logic               centre;
    logic [12:0]        sum_lr;
    logic [11:0]        sp;
    logic signed [12:0] e;
    logic signed [12:0] err;
    logic signed [6:0]  gain_s;
    logic signed [19:0] prod;
    logic signed [20:0] nom_s;
    logic [13:0]        dn_duty;
    logic [13:0]        up_duty;

    // Clamp to [clamp_lo, clamp_hi]; clamp_lo <= clamp_hi always holds
    function automatic logic [13:0] clamp_duty(input logic signed [20:0] d,
                                               input logic [13:0] lo,
                                               input logic [13:0] hi);
        logic signed [20:0] lo_s;
        logic signed [20:0] hi_s;
        lo_s = {7'd0, lo};
        hi_s = {7'd0, hi};
        if (d < lo_s) begin
            clamp_duty = lo;
        end else if (d > hi_s) begin
            clamp_duty = hi;
        end else begin
            clamp_duty = d[13:0];
        end
    endfunction

    always_comb begin
        nom      = cfg.fast_mode ? wfdc_pkg::NOM_FAST : wfdc_pkg::NOM_SLOW;
        front_mm = cfg.fast_mode ? wfdc_pkg::FRONT_FAST_MM : wfdc_pkg::FRONT_SLOW_MM;
        stuck_mm = cfg.fast_mode ? wfdc_pkg::STUCK_FAST_MM : wfdc_pkg::STUCK_SLOW_MM;
        exit_mm  = cfg.fast_mode ? wfdc_pkg::EXIT_FAST_MM : wfdc_pkg::EXIT_SLOW_MM;

        l_out_band = (item.left_mm < cfg.near_limit_mm) || (item.left_mm > cfg.far_limit_mm);
        r_out_band = (item.right_mm < cfg.near_limit_mm) || (item.right_mm > cfg.far_limit_mm);
        follow_l   = l_out_band && (item.right_mm >= wfdc_pkg::OPEN_SIDE_MM);
        follow_r   = r_out_band && (item.left_mm > wfdc_pkg::OPEN_SIDE_MM);
        centre     = (item.left_mm < wfdc_pkg::OPEN_SIDE_MM)
                     && (item.right_mm < wfdc_pkg::OPEN_SIDE_MM);

        // centring set point: mean of both walls when both lie past mid
        sum_lr = {1'b0, item.left_mm} + {1'b0, item.right_mm};
        if ((item.left_mm > cfg.mid_mm) && (item.right_mm > cfg.mid_mm)) begin
            sp = sum_lr[12:1];
        end else begin
            sp = cfg.mid_mm;
        end
        if (item.left_mm < item.right_mm) begin
            e = $signed({1'b0, item.left_mm}) - $signed({1'b0, sp});
        end else begin
            e = $signed({1'b0, sp}) - $signed({1'b0, item.right_mm});
        end

        // one shared multiplier for all three P branches
        if (follow_l) begin
            err = $signed({1'b0, item.left_mm}) - $signed({1'b0, cfg.mid_mm});
        end else if (follow_r) begin
            err = $signed({1'b0, item.right_mm}) - $signed({1'b0, cfg.mid_mm});
        end else begin
            err = e;
        end
        gain_s = $signed({1'b0, cfg.gain});
        prod   = err * gain_s;
        nom_s  = $signed({7'd0, nom});
        dn_duty = clamp_duty(nom_s - {prod[19], prod}, cfg.clamp_lo, cfg.clamp_hi);
        up_duty = clamp_duty(nom_s + {prod[19], prod}, cfg.clamp_lo, cfg.clamp_hi);

        // default: repeat held drive
        st_next        = st;
        res.drive_mode = st.held_mode;
        res.left_duty  = st.held_left_duty;
        res.right_duty = st.held_right_duty;

        if (item.bump) begin
            st_next.reversing       = 1'b0;
            st_next.held_mode       = wfdc_pkg::MODE_FWD;
            st_next.held_left_duty  = nom;
            st_next.held_right_duty = nom;
            res.drive_mode = wfdc_pkg::MODE_STOP;
            res.left_duty  = 14'd0;
            res.right_duty = 14'd0;
        end else if (st.reversing) begin
            if (item.center_mm < exit_mm) begin
                res.drive_mode = wfdc_pkg::MODE_BACK;
                res.left_duty  = wfdc_pkg::BACK_LEFT_DUTY;
                res.right_duty = wfdc_pkg::BACK_RIGHT_DUTY;
            end else begin
                st_next.reversing = 1'b0;
                res.drive_mode = wfdc_pkg::MODE_FWD;
                res.left_duty  = nom;
                res.right_duty = nom;
            end
        end else if ((item.center_mm < stuck_mm) && (item.right_mm < wfdc_pkg::SIDE_CLEAR_MM)
                     && (item.left_mm < wfdc_pkg::SIDE_CLEAR_MM)) begin
            st_next.reversing = 1'b1;
            res.drive_mode = wfdc_pkg::MODE_BACK;
            res.left_duty  = wfdc_pkg::BACK_LEFT_DUTY;
            res.right_duty = wfdc_pkg::BACK_RIGHT_DUTY;
        end else if ((item.center_mm < front_mm)
                     && (item.right_mm >= wfdc_pkg::SIDE_CLEAR_MM)) begin
            if (cfg.fast_mode) begin
                res.drive_mode = wfdc_pkg::MODE_SPIN_R;
                res.left_duty  = wfdc_pkg::NOM_FAST;
                res.right_duty = wfdc_pkg::NOM_FAST;
            end else begin
                res.drive_mode = wfdc_pkg::MODE_FWD;
                res.left_duty  = wfdc_pkg::NOM_SLOW;
                res.right_duty = wfdc_pkg::TURN_SLOW_DUTY;
            end
        end else if ((item.center_mm < front_mm)
                     && (item.left_mm >= wfdc_pkg::SIDE_CLEAR_MM)) begin
            if (cfg.fast_mode) begin
                res.drive_mode = wfdc_pkg::MODE_SPIN_L;
                res.left_duty  = wfdc_pkg::NOM_FAST;
                res.right_duty = wfdc_pkg::NOM_FAST;
            end else begin
                res.drive_mode = wfdc_pkg::MODE_FWD;
                res.left_duty  = wfdc_pkg::TURN_SLOW_DUTY;
                res.right_duty = wfdc_pkg::NOM_SLOW;
            end
        end else if (follow_l) begin
            res.drive_mode = wfdc_pkg::MODE_FWD;
            res.left_duty  = dn_duty;
            res.right_duty = nom;
        end else if (follow_r) begin
            res.drive_mode = wfdc_pkg::MODE_FWD;
            res.left_duty  = nom;
            res.right_duty = dn_duty;
        end else if (centre) begin
            res.drive_mode = wfdc_pkg::MODE_FWD;
            res.left_duty  = dn_duty;
            res.right_duty = up_duty;
        end

        // every branch but bump, corner hold/entry and the fallback stores its drive
        if (!item.bump && !(st.reversing && (item.center_mm < exit_mm))
            && (res.drive_mode != wfdc_pkg::MODE_BACK)) begin
            st_next.held_mode       = res.drive_mode;
            st_next.held_left_duty  = res.left_duty;
            st_next.held_right_duty = res.right_duty;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wall_follow_drive_control.sv =====
// ----------------------------------------------------------------------------
// wall_follow_drive_control
// Path: request into the input register, then result into the result register.
// Throughput: one request per cycle while m_ready is not held low; the single-pass
// decision logic between the input and result registers sets this figure.
// Reset (aresetn low, synchronous): pipeline empty, config at defaults,
// not reversing, held drive forward at 3750/3750.
// ----------------------------------------------------------------------------
`default_nettype none

module wall_follow_drive_control (
    input  wire         aclk,
    input  wire         aresetn,
    // config write port
    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_index,
    input  wire  [12:0] cfg_wdata,
    // request channel
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [11:0] s_left_mm,
    input  wire  [11:0] s_center_mm,
    input  wire  [11:0] s_right_mm,
    input  wire         s_bump,
    // result channel
    output logic        m_valid,
    input  wire         m_ready,
    output logic [2:0]  m_drive_mode,
    output logic [13:0] m_left_duty,
    output logic [13:0] m_right_duty
);

    // ---- configuration registers ----
    // Derived values (mid point, clamp bounds) are registered from the
    // next config values so they are always in step with the registers.
    wfdc_pkg::cfg_t cfg_reg;
    wfdc_pkg::cfg_t cfg_next;
    logic [12:0]    duty_swing_reg;
    logic [12:0]    duty_swing_next;
    logic [12:0]    mid_sum;
    logic [13:0]    nom_next;
    logic [14:0]    hi_sum;

    always_comb begin
        cfg_next        = cfg_reg;
        duty_swing_next = duty_swing_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                wfdc_pkg::REG_FAST_MODE:  cfg_next.fast_mode     = cfg_wdata[0];
                wfdc_pkg::REG_GAIN:       cfg_next.gain          = cfg_wdata[5:0];
                wfdc_pkg::REG_NEAR_LIMIT: cfg_next.near_limit_mm = cfg_wdata[11:0];
                wfdc_pkg::REG_FAR_LIMIT:  cfg_next.far_limit_mm  = cfg_wdata[11:0];
                wfdc_pkg::REG_DUTY_SWING: duty_swing_next        = cfg_wdata;
                default: ; // unused index: ignored
            endcase
        end
        mid_sum         = {1'b0, cfg_next.near_limit_mm} + {1'b0, cfg_next.far_limit_mm};
        cfg_next.mid_mm = mid_sum[12:1];
        nom_next = cfg_next.fast_mode ? wfdc_pkg::NOM_FAST : wfdc_pkg::NOM_SLOW;
        // lower bound saturates at zero when the swing exceeds nominal
        if ({1'b0, duty_swing_next} > nom_next) begin
            cfg_next.clamp_lo = 14'd0;
        end else begin
            cfg_next.clamp_lo = nom_next - {1'b0, duty_swing_next};
        end
        hi_sum            = {1'b0, nom_next} + {2'b0, duty_swing_next};
        cfg_next.clamp_hi = hi_sum[13:0]; // at most 13191, fits
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_mode     <= 1'b0;
            cfg_reg.gain          <= wfdc_pkg::GAIN_RST;
            cfg_reg.near_limit_mm <= wfdc_pkg::NEAR_LIMIT_RST;
            cfg_reg.far_limit_mm  <= wfdc_pkg::FAR_LIMIT_RST;
            cfg_reg.mid_mm        <= 12'd300;
            cfg_reg.clamp_lo      <= 14'd1500;
            cfg_reg.clamp_hi      <= 14'd6000;
            duty_swing_reg        <= wfdc_pkg::DUTY_SWING_RST;
        end else begin
            cfg_reg        <= cfg_next;
            duty_swing_reg <= duty_swing_next;
        end
    end

    // ---- pipeline control ----
    // Input stage holds one request; it advances into the result register
    // whenever that register is empty or being drained this cycle, so a
    // new request is taken while a finished result still waits.
    logic            in_valid_reg;
    wfdc_pkg::item_t in_item_reg;
    logic            out_valid_reg;
    wfdc_pkg::result_t out_res_reg;
    logic            advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.left_mm   <= s_left_mm;
            in_item_reg.center_mm <= s_center_mm;
            in_item_reg.right_mm  <= s_right_mm;
            in_item_reg.bump      <= s_bump;
        end
    end

    // ---- decision logic and controller state ----
    wfdc_pkg::state_t  st_reg;
    wfdc_pkg::state_t  st_next;
    wfdc_pkg::result_t res_next;

    wfdc_decide u_decide (
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .st      (st_reg),
        .res     (res_next),
        .st_next (st_next)
    );

    // state moves only when a request is committed to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.reversing       <= 1'b0;
            st_reg.held_mode       <= wfdc_pkg::MODE_FWD;
            st_reg.held_left_duty  <= wfdc_pkg::NOM_SLOW;
            st_reg.held_right_duty <= wfdc_pkg::NOM_SLOW;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // ---- result register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_drive_mode = out_res_reg.drive_mode;
    assign m_left_duty  = out_res_reg.left_duty;
    assign m_right_duty = out_res_reg.right_duty;

`ifndef SYNTHESIS
    // a stop result always has both wheels off
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_drive_mode == wfdc_pkg::MODE_STOP))
        |-> ((m_left_duty == 14'd0) && (m_right_duty == 14'd0)))
    else $error("stop result with non-zero duty");

    // a backward result always uses the fixed reverse duties
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_drive_mode == wfdc_pkg::MODE_BACK))
        |-> ((m_left_duty == wfdc_pkg::BACK_LEFT_DUTY)
             && (m_right_duty == wfdc_pkg::BACK_RIGHT_DUTY)))
    else $error("backward result with wrong duties");

    // entering the corner reverse produces a backward result
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(st_reg.reversing) |-> (m_valid && (m_drive_mode == wfdc_pkg::MODE_BACK)))
    else $error("reverse entry without backward result");

    // the held drive is never backward or stop
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.held_mode != wfdc_pkg::MODE_BACK) && (st_reg.held_mode != wfdc_pkg::MODE_STOP))
    else $error("held mode is backward or stop");

    // state changes only when a request is committed
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(advance) && $past(aresetn) |-> $stable(st_reg))
    else $error("controller state moved without a request");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_wall_follow_drive_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wall_follow_drive_control
// Self-checking bench for the wall-following drive control block. Sensor
// requests are sent over a valid/ready channel. Every accepted request runs
// through a local model of the decision chain, and each drive result that
// comes back is compared with the oldest prediction. Directed tests cover
// corner reversing, front turns, wall following, centring, bump and the
// clamp limits. Random phases then run under several register settings and
// idle profiles, plus one long result hold-off that backs up the input.
// ----------------------------------------------------------------------------

module tb_wall_follow_drive_control;

    localparam int CLK_HALF_NS  = 2;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 400000;
    // result register plus input register, with some margin
    localparam int SETTLE_CYCLES = 4;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_profile_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [11:0] s_left_mm;
    logic [11:0] s_center_mm;
    logic [11:0] s_right_mm;
    logic        s_bump;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_drive_mode;
    logic [13:0] m_left_duty;
    logic [13:0] m_right_duty;

    wall_follow_drive_control DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_left_mm    (s_left_mm),
        .s_center_mm  (s_center_mm),
        .s_right_mm   (s_right_mm),
        .s_bump       (s_bump),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_drive_mode (m_drive_mode),
        .m_left_duty  (m_left_duty),
        .m_right_duty (m_right_duty)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    // Local copy of the registers, kept in step with every write
    logic        cfg_fast  = 1'b0;
    logic [5:0]  cfg_gain  = wfdc_pkg::GAIN_RST;
    logic [11:0] cfg_near  = wfdc_pkg::NEAR_LIMIT_RST;
    logic [11:0] cfg_far   = wfdc_pkg::FAR_LIMIT_RST;
    logic [12:0] cfg_swing = wfdc_pkg::DUTY_SWING_RST;

    // Local copy of the controller state
    logic        st_reversing  = 1'b0;
    logic [2:0]  st_held_mode  = wfdc_pkg::MODE_FWD;
    logic [13:0] st_held_left  = wfdc_pkg::NOM_SLOW;
    logic [13:0] st_held_right = wfdc_pkg::NOM_SLOW;

    wfdc_pkg::result_t predicted_drives[$];
    wfdc_pkg::result_t oldest_drive;
    int          fail_count    = 0;
    int          cycle_count   = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;

    // long result hold-off, run by its own process
    bit          hold_request = 1'b0;
    int          hold_len     = 0;
    logic        hold_active;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF_NS aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drive model
    // ------------------------------------------------------------------
    function automatic wfdc_pkg::result_t drive_word(input logic [2:0] mode, input int l,
                                                     input int r);
        wfdc_pkg::result_t w;
        w.drive_mode = mode;
        w.left_duty  = l[13:0];
        w.right_duty = r[13:0];
        return w;
    endfunction

    // result that also becomes the held drive for later no-branch ticks
    function automatic wfdc_pkg::result_t hold_drive(input logic [2:0] mode, input int l,
                                                     input int r);
        st_held_mode  = mode;
        st_held_left  = l[13:0];
        st_held_right = r[13:0];
        return drive_word(mode, l, r);
    endfunction

    // nominal +/- swing, lower bound floored at zero
    function automatic int clamp_duty(input int d, input int nom);
        int lo;
        int hi;
        int swing;
        swing = int'(cfg_swing);
        lo = nom - swing;
        hi = nom + swing;
        if (lo < 0) lo = 0;
        if (d < lo) d = lo;
        if (d > hi) d = hi;
        return d;
    endfunction

    function automatic wfdc_pkg::result_t predict_drive_command(input wfdc_pkg::item_t req);
        int l, c, r;
        int nom, front, stuck, exit_mm, side_clear, open_side;
        int nearl, farl, mid, k, sp, e, ld, rd;
        int nom_fast, nom_slow, turn_slow, back_l, back_r;
        l          = int'(req.left_mm);
        c          = int'(req.center_mm);
        r          = int'(req.right_mm);
        nom_fast   = int'(wfdc_pkg::NOM_FAST);
        nom_slow   = int'(wfdc_pkg::NOM_SLOW);
        turn_slow  = int'(wfdc_pkg::TURN_SLOW_DUTY);
        back_l     = int'(wfdc_pkg::BACK_LEFT_DUTY);
        back_r     = int'(wfdc_pkg::BACK_RIGHT_DUTY);
        nom        = cfg_fast ? nom_fast : nom_slow;
        front      = cfg_fast ? int'(wfdc_pkg::FRONT_FAST_MM) : int'(wfdc_pkg::FRONT_SLOW_MM);
        stuck      = cfg_fast ? int'(wfdc_pkg::STUCK_FAST_MM) : int'(wfdc_pkg::STUCK_SLOW_MM);
        exit_mm    = cfg_fast ? int'(wfdc_pkg::EXIT_FAST_MM) : int'(wfdc_pkg::EXIT_SLOW_MM);
        side_clear = int'(wfdc_pkg::SIDE_CLEAR_MM);
        open_side  = int'(wfdc_pkg::OPEN_SIDE_MM);
        nearl      = int'(cfg_near);
        farl       = int'(cfg_far);
        mid        = (nearl + farl) / 2;
        k          = int'(cfg_gain);

        // bump: stop, forget any reverse, held drive back to nominal
        if (req.bump) begin
            st_reversing  = 1'b0;
            st_held_mode  = wfdc_pkg::MODE_FWD;
            st_held_left  = nom[13:0];
            st_held_right = nom[13:0];
            return drive_word(wfdc_pkg::MODE_STOP, 0, 0);
        end
        // backing out of a corner until the front has cleared
        if (st_reversing) begin
            if (c < exit_mm)
                return drive_word(wfdc_pkg::MODE_BACK, back_l, back_r);
            st_reversing = 1'b0;
            return hold_drive(wfdc_pkg::MODE_FWD, nom, nom);
        end
        // boxed in on three sides: start reversing
        if (c < stuck && r < side_clear && l < side_clear) begin
            st_reversing = 1'b1;
            return drive_word(wfdc_pkg::MODE_BACK, back_l, back_r);
        end
        // front wall: turn right if there is room, else left
        if (c < front && r >= side_clear) begin
            if (cfg_fast) return hold_drive(wfdc_pkg::MODE_SPIN_R, nom_fast, nom_fast);
            return hold_drive(wfdc_pkg::MODE_FWD, nom_slow, turn_slow);
        end
        if (c < front && l >= side_clear) begin
            if (cfg_fast) return hold_drive(wfdc_pkg::MODE_SPIN_L, nom_fast, nom_fast);
            return hold_drive(wfdc_pkg::MODE_FWD, turn_slow, nom_slow);
        end
        // single-wall following, left side first
        if ((l < nearl || l > farl) && r >= open_side) begin
            ld = clamp_duty(nom - (l - mid) * k, nom);
            return hold_drive(wfdc_pkg::MODE_FWD, ld, clamp_duty(nom, nom));
        end
        if ((r < nearl || r > farl) && l > open_side) begin
            rd = clamp_duty(nom - (r - mid) * k, nom);
            return hold_drive(wfdc_pkg::MODE_FWD, clamp_duty(nom, nom), rd);
        end
        // corridor: steer towards the middle
        if (l < open_side && r < open_side) begin
            sp = (l > mid && r > mid) ? (l + r) / 2 : mid;
            e  = (l < r) ? (l - sp) : (sp - r);
            rd = clamp_duty(nom + e * k, nom);
            ld = clamp_duty(nom - e * k, nom);
            return hold_drive(wfdc_pkg::MODE_FWD, ld, rd);
        end
        // nothing matched: repeat the held drive
        return drive_word(st_held_mode, int'(st_held_left), int'(st_held_right));
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready generation, hold-off, checker
    // ------------------------------------------------------------------
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!aresetn || hold_active)
                m_ready <= 1'b0;
            else
                m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // counts out the hold-off in cycles while the sender keeps pushing
    initial begin
        hold_active <= 1'b0;
        wait (hold_request);
        @(posedge aclk);
        hold_active <= 1'b1;
        repeat (hold_len) @(posedge aclk);
        hold_active <= 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (predicted_drives.size() == 0) begin
                $error("result with no request outstanding: mode %0d, duties %0d/%0d",
                       m_drive_mode, m_left_duty, m_right_duty);
                fail_count++;
            end else begin
                oldest_drive = predicted_drives.pop_front();
                if (m_drive_mode !== oldest_drive.drive_mode) begin
                    $error("drive_mode: expected %0d, got %0d",
                           oldest_drive.drive_mode, m_drive_mode);
                    fail_count++;
                end
                if (m_left_duty !== oldest_drive.left_duty) begin
                    $error("left_duty: expected %0d, got %0d",
                           oldest_drive.left_duty, m_left_duty);
                    fail_count++;
                end
                if (m_right_duty !== oldest_drive.right_duty) begin
                    $error("right_duty: expected %0d, got %0d",
                           oldest_drive.right_duty, m_right_duty);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    function automatic wfdc_pkg::item_t sensor_item(input int l, input int c, input int r,
                                                    input logic bump);
        wfdc_pkg::item_t req;
        req.left_mm   = l[11:0];
        req.center_mm = c[11:0];
        req.right_mm  = r[11:0];
        req.bump      = bump;
        return req;
    endfunction

    // Valid goes up on its own schedule and stays up until accepted. If the
    // next request follows at once, valid is simply left high.
    task automatic send_request(input wfdc_pkg::item_t req);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_left_mm   <= req.left_mm;
        s_center_mm <= req.center_mm;
        s_right_mm  <= req.right_mm;
        s_bump      <= req.bump;
        do @(posedge aclk); while (!s_ready);
        predicted_drives.push_back(predict_drive_command(req));
    endtask

    // Wait for every prediction to be matched, then let the pipe settle
    task automatic drain_results;
        s_valid <= 1'b0;
        while (predicted_drives.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Register writes (only ever issued with the block drained)
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [2:0] idx, input logic [12:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            wfdc_pkg::REG_FAST_MODE:  cfg_fast  = data[0];
            wfdc_pkg::REG_GAIN:       cfg_gain  = data[5:0];
            wfdc_pkg::REG_NEAR_LIMIT: cfg_near  = data[11:0];
            wfdc_pkg::REG_FAR_LIMIT:  cfg_far   = data[11:0];
            wfdc_pkg::REG_DUTY_SWING: cfg_swing = data[12:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [12:0] fast, input logic [12:0] gain,
                                 input logic [12:0] near, input logic [12:0] far,
                                 input logic [12:0] swing);
        cfg_write(wfdc_pkg::REG_FAST_MODE, fast);
        cfg_write(wfdc_pkg::REG_GAIN, gain);
        cfg_write(wfdc_pkg::REG_NEAR_LIMIT, near);
        cfg_write(wfdc_pkg::REG_FAR_LIMIT, far);
        cfg_write(wfdc_pkg::REG_DUTY_SWING, swing);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // reset gain, band and swing with the given speed setting
    task automatic load_defaults(input logic [12:0] fast);
        load_settings(fast, 13'(wfdc_pkg::GAIN_RST), 13'(wfdc_pkg::NEAR_LIMIT_RST),
                      13'(wfdc_pkg::FAR_LIMIT_RST), wfdc_pkg::DUTY_SWING_RST);
    endtask

    task automatic set_idling(input idle_profile_t profile);
        case (profile)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 72; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 72; end
            default:       begin send_idle_pct = 26; stall_pct = 26; end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Random request shaping
    // ------------------------------------------------------------------
    // mostly close to the thresholds, sometimes anywhere in range
    function automatic logic [11:0] random_mm();
        if ($urandom_range(99) < 85) return 12'($urandom_range(700, 0));
        return 12'($urandom_range(4095, 0));
    endfunction

    function automatic wfdc_pkg::item_t random_sensor_item();
        wfdc_pkg::item_t req;
        int pick;
        int stuck_mm;
        int front_mm;
        int exit_mm;
        int side_clear;
        int open_side;
        stuck_mm   = cfg_fast ? int'(wfdc_pkg::STUCK_FAST_MM) : int'(wfdc_pkg::STUCK_SLOW_MM);
        front_mm   = cfg_fast ? int'(wfdc_pkg::FRONT_FAST_MM) : int'(wfdc_pkg::FRONT_SLOW_MM);
        exit_mm    = cfg_fast ? int'(wfdc_pkg::EXIT_FAST_MM) : int'(wfdc_pkg::EXIT_SLOW_MM);
        side_clear = int'(wfdc_pkg::SIDE_CLEAR_MM);
        open_side  = int'(wfdc_pkg::OPEN_SIDE_MM);
        req.left_mm   = random_mm();
        req.center_mm = random_mm();
        req.right_mm  = random_mm();
        req.bump      = 1'b0;
        pick = $urandom_range(99);
        if (pick < 3) begin
            req.bump = 1'b1;
        end else if (pick < 13) begin
            // full-width noise, every bit toggles
            req.left_mm   = 12'($urandom);
            req.center_mm = 12'($urandom);
            req.right_mm  = 12'($urandom);
        end else if (st_reversing && pick < 70) begin
            // creep the front reading around the exit threshold
            req.center_mm = 12'($urandom_range(exit_mm + 40, exit_mm - 40));
        end else if (pick < 25) begin
            req.center_mm = 12'($urandom_range(stuck_mm - 1, 0));
            req.left_mm   = 12'($urandom_range(side_clear - 1, 0));
            req.right_mm  = 12'($urandom_range(side_clear - 1, 0));
        end else if (pick < 40) begin
            req.center_mm = 12'($urandom_range(front_mm - 1, 0));
            if ($urandom_range(1))
                req.right_mm = 12'($urandom_range(900, side_clear));
            else
                req.left_mm = 12'($urandom_range(900, side_clear));
        end else if (pick < 60) begin
            // one wall only, the other side open
            req.center_mm = 12'($urandom_range(4095, front_mm));
            if ($urandom_range(1)) begin
                req.right_mm = 12'($urandom_range(1200, open_side));
            end else begin
                req.left_mm = 12'($urandom_range(1200, open_side + 1));
                req.right_mm = random_mm();
            end
        end else if (pick < 80) begin
            req.center_mm = 12'($urandom_range(4095, front_mm));
            req.left_mm   = 12'($urandom_range(open_side - 1, 0));
            req.right_mm  = 12'($urandom_range(open_side - 1, 0));
        end
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    task automatic test_corner_reverse;
        // slow: enter at all-zero, hold just under exit, leave at exit
        send_request(sensor_item(0, 0, 0, 1'b0));
        send_request(sensor_item(100, wfdc_pkg::EXIT_SLOW_MM - 1, 100, 1'b0));
        send_request(sensor_item(0, wfdc_pkg::EXIT_SLOW_MM, 0, 1'b0));
        drain_results();
        load_defaults(13'd1);
        send_request(sensor_item(0, wfdc_pkg::STUCK_FAST_MM - 1, 0, 1'b0));
        send_request(sensor_item(300, wfdc_pkg::EXIT_FAST_MM - 1, 300, 1'b0));
        send_request(sensor_item(0, wfdc_pkg::EXIT_FAST_MM, 0, 1'b0));
        drain_results();
    endtask

    task automatic test_front_turns;
        load_defaults(13'd0);
        send_request(sensor_item(100, 300, 400, 1'b0));
        send_request(sensor_item(400, 300, 100, 1'b0));
        drain_results();
        load_defaults(13'd1);
        send_request(sensor_item(100, wfdc_pkg::FRONT_FAST_MM - 1,
                                 wfdc_pkg::SIDE_CLEAR_MM, 1'b0));
        send_request(sensor_item(wfdc_pkg::SIDE_CLEAR_MM, wfdc_pkg::FRONT_FAST_MM - 1,
                                 100, 1'b0));
        drain_results();
    endtask

    task automatic test_side_following;
        load_defaults(13'd0);
        // all fields at maximum: left far out of band, clamps low
        send_request(sensor_item(4095, 4095, 4095, 1'b0));
        send_request(sensor_item(400, 1000, 600, 1'b0));
        send_request(sensor_item(600, 1000, 200, 1'b0));
        drain_results();
    endtask

    task automatic test_centring_and_hold;
        send_request(sensor_item(300, 1000, 300, 1'b0));
        send_request(sensor_item(200, 1000, 450, 1'b0));
        // both sides past the target: set point is their mean
        send_request(sensor_item(340, 1000, 320, 1'b0));
        // in-band left, open right with left closed: no branch, held drive
        send_request(sensor_item(300, 1000, 600, 1'b0));
        drain_results();
    endtask

    task automatic test_bump;
        send_request(sensor_item(4095, 4095, 4095, 1'b1));
        send_request(sensor_item(300, 1000, 600, 1'b0));
        // bump in the middle of a reverse cancels it
        send_request(sensor_item(0, 0, 0, 1'b0));
        send_request(sensor_item(0, 0, 0, 1'b1));
        send_request(sensor_item(0, 400, 0, 1'b0));
        drain_results();
    endtask

    task automatic test_clamp_bounds;
        // swing above nominal: lower bound floors at zero, upper at its top
        load_settings(13'd1, 13'd63, 13'(wfdc_pkg::NEAR_LIMIT_RST),
                      13'(wfdc_pkg::FAR_LIMIT_RST), 13'd7499);
        send_request(sensor_item(4095, 4095, 4095, 1'b0));
        send_request(sensor_item(0, 1000, 600, 1'b0));
        drain_results();
    endtask

    task automatic test_inverted_band;
        logic [3:0] spare_idx;
        // near above far, used as written; zero swing pins the duties
        load_settings(13'd0, 13'd63, 13'd4095, 13'd0, 13'd0);
        send_request(sensor_item(2000, 2000, 2000, 1'b0));
        drain_results();
        // writes past the last register must leave the settings alone
        for (spare_idx = 4'(wfdc_pkg::REG_DUTY_SWING) + 4'd1; spare_idx < 4'd8;
             spare_idx++)
            cfg_write(spare_idx[2:0], 13'h1FFF);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        send_request(sensor_item(2000, 2000, 2000, 1'b0));
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Random tests
    // ------------------------------------------------------------------
    task automatic test_random_phase(input idle_profile_t profile,
                                     input logic [12:0] fast, input logic [12:0] gain,
                                     input logic [12:0] near, input logic [12:0] far,
                                     input logic [12:0] swing, input int count);
        drain_results();
        load_settings(fast, gain, near, far, swing);
        set_idling(profile);
        repeat (count) send_request(random_sensor_item());
        drain_results();
    endtask

    // Result side blocked for a long while; the pipe fills and s_ready drops
    task automatic test_result_backpressure;
        drain_results();
        load_defaults(13'd0);
        set_idling(IDLE_NONE);
        hold_len     = 200;
        hold_request = 1'b1;
        repeat (40) send_request(random_sensor_item());
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= wfdc_pkg::REG_FAST_MODE;
        cfg_wdata   <= '0;
        s_valid     <= 1'b0;
        s_left_mm   <= '0;
        s_center_mm <= '0;
        s_right_mm  <= '0;
        s_bump      <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(IDLE_NONE);
        test_corner_reverse();
        test_front_turns();
        test_side_following();
        test_centring_and_hold();
        test_bump();
        test_clamp_bounds();
        test_inverted_band();

        test_random_phase(IDLE_NONE, 13'd0, 13'(wfdc_pkg::GAIN_RST),
                          13'(wfdc_pkg::NEAR_LIMIT_RST), 13'(wfdc_pkg::FAR_LIMIT_RST),
                          wfdc_pkg::DUTY_SWING_RST, 52);
        test_random_phase(IDLE_SENDER, 13'd1, 13'(wfdc_pkg::GAIN_RST),
                          13'(wfdc_pkg::NEAR_LIMIT_RST), 13'(wfdc_pkg::FAR_LIMIT_RST),
                          wfdc_pkg::DUTY_SWING_RST, 52);
        test_random_phase(IDLE_RECEIVER, 13'd0, 13'd63, 13'(wfdc_pkg::NEAR_LIMIT_RST),
                          13'(wfdc_pkg::FAR_LIMIT_RST), 13'd7499, 52);
        test_random_phase(IDLE_BOTH, 13'd1, 13'd0, 13'(wfdc_pkg::NEAR_LIMIT_RST),
                          13'(wfdc_pkg::FAR_LIMIT_RST), 13'd0, 52);
        test_random_phase(IDLE_NONE, 13'd1, 13'd63, 13'd0, 13'd4095, 13'd7499, 52);
        test_random_phase(IDLE_SENDER, 13'd0, 13'($urandom_range(63, 0)),
                          13'($urandom_range(600, 0)), 13'($urandom_range(600, 0)),
                          13'($urandom_range(7499, 0)), 52);
        // raw 13-bit data: narrower registers keep their low bits only
        test_random_phase(IDLE_RECEIVER, 13'($urandom), 13'($urandom), 13'($urandom),
                          13'($urandom), 13'($urandom), 52);
        test_random_phase(IDLE_BOTH, 13'd0, 13'd37, 13'd400, 13'd200, 13'd1000, 52);
        test_result_backpressure();

        drain_results();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
